### hw/rtl/text_command_to_midi_packets_macros.svh
// Assertion macros for the text command to MIDI packet block.
`ifndef TEXT_COMMAND_TO_MIDI_PACKETS_MACROS_SVH
`define TEXT_COMMAND_TO_MIDI_PACKETS_MACROS_SVH
`ifndef SYNTHESIS
// Check that expr holds in the same cycle as cond.
`define TCMP_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);
// Check that expr holds in the cycle after cond.
`define TCMP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);
`else
`define TCMP_ASSERT_SAME(label, clk, rst, cond, expr, msg)
`define TCMP_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

### hw/rtl/tcmp_pkg.sv
// Types and constants shared by the text command to MIDI packet block.
package tcmp_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_command;
  } char_item_t;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] status_byte;
    logic [7:0] note_number;
    logic [7:0] note_velocity;
    logic       last_packet;
  } packet_t;

  // Characters
  localparam logic [7:0] CH_M       = 8'h4D;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_FEED    = 8'h0C;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Action codes
  localparam logic [1:0] ACT_STROKE  = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // Field parser phases
  localparam logic [1:0] PH_BLANK  = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // USB-MIDI packet constants
  localparam logic [3:0] CIN_NOTE_ON     = 4'h9;
  localparam logic [3:0] CIN_NOTE_OFF    = 4'h8;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] VELOCITY_FULL   = 8'd127;

  // Signed field value from magnitude and sign, modulo 256.
  function automatic logic [7:0] field_value(input logic negative, input logic [7:0] mag);
    field_value = negative ? (8'd0 - mag) : mag;
  endfunction

endpackage

### hw/rtl/tcmp_stream_if.sv
// Valid/ready stream interface with a typed payload.
interface tcmp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/text_command_to_midi_packets.sv
// Text command parser that turns "M<action>...:note,velocity,channel" into USB-MIDI packets.
//
// Characters arrive on cmd, one per transfer, with end_of_command set on the last one.
// The command is cut at the first CR or LF. A command whose first character is 'M' and
// that holds a ':' before the cut yields packets on its last character: 'P' as second
// character gives one note-on, 'R' one note-off, anything else a note-on followed by a
// note-off. Fields after the colon are read like atol (blanks, sign, digits), each
// wrapped to 8 bits; one field is the note (velocity 127), two give note and velocity,
// three or more give note, velocity and, from the field after the last comma, the
// channel that is OR'ed into the status byte. Packets leave on pkt, last_packet set on
// the final one of a command. Rate: one character per cycle while the packet register has
// room. The parser computes its next state combinationally between the input transfer and
// a two-entry packet register; a character is taken whenever that register is empty or its
// only packet leaves in the same cycle, so a stroke holds cmd off until its note-off leaves,
// as does a stalled pkt side. A command's first packet is valid the cycle after its end.
module text_command_to_midi_packets (
  input  logic              clk,
  input  logic              rst,
  tcmp_stream_if.sink       cmd,
  tcmp_stream_if.source     pkt
);

  `include "text_command_to_midi_packets_macros.svh"

  // Parser state
  logic [1:0] char_position, char_position_next;
  logic       starts_with_m, starts_with_m_next;
  logic       line_ended, line_ended_next;
  logic [1:0] action_kind, action_kind_next;
  logic       colon_seen, colon_seen_next;
  logic [1:0] comma_count, comma_count_next;
  logic [1:0] field_phase, field_phase_next;
  logic       field_negative, field_negative_next;
  logic [7:0] field_accumulator, field_accumulator_next;
  logic [7:0] saved_note, saved_note_next;
  logic [7:0] saved_velocity, saved_velocity_next;

  // Packet register: slot0 is the head, slot1 the note-off that follows in a stroke
  tcmp_pkg::packet_t slot0, slot0_next;
  tcmp_pkg::packet_t slot1, slot1_next;
  logic [1:0]        count, count_next;

  logic       cmd_xfer;
  logic       pkt_xfer;
  logic [7:0] c;
  logic       is_digit;
  logic [7:0] digit_val;
  logic       emit;
  logic [7:0] cur_value;
  logic [7:0] note, velocity, channel;
  tcmp_pkg::packet_t on_pkt, off_pkt;

  // Accept a character only when the packet register drains empty this cycle.
  assign cmd.ready = (count == 2'd0) || ((count == 2'd1) && pkt.ready);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign pkt_xfer  = pkt.valid && pkt.ready;

  assign pkt.valid   = (count != 2'd0);
  assign pkt.payload = slot0;

  assign c         = cmd.payload.char_byte;
  assign is_digit  = (c >= tcmp_pkg::CH_ZERO) && (c <= tcmp_pkg::CH_NINE);
  assign digit_val = c - tcmp_pkg::CH_ZERO;

  // Running parser update for one character.
  always_comb begin
    char_position_next     = char_position;
    starts_with_m_next     = starts_with_m;
    line_ended_next        = line_ended;
    action_kind_next       = action_kind;
    colon_seen_next        = colon_seen;
    comma_count_next       = comma_count;
    field_phase_next       = field_phase;
    field_negative_next    = field_negative;
    field_accumulator_next = field_accumulator;
    saved_note_next        = saved_note;
    saved_velocity_next    = saved_velocity;

    if (char_position == 2'd0) begin
      starts_with_m_next = (c == tcmp_pkg::CH_M);
    end else if (starts_with_m && !line_ended) begin
      if ((c == tcmp_pkg::CH_LF) || (c == tcmp_pkg::CH_CR)) begin
        line_ended_next = 1'b1;
      end else begin
        // Second character picks the action.
        if (char_position == 2'd1) begin
          if (c == tcmp_pkg::CH_P) begin
            action_kind_next = tcmp_pkg::ACT_PRESS;
          end else if (c == tcmp_pkg::CH_R) begin
            action_kind_next = tcmp_pkg::ACT_RELEASE;
          end else begin
            action_kind_next = tcmp_pkg::ACT_STROKE;
          end
        end
        if (!colon_seen) begin
          if (c == tcmp_pkg::CH_COLON) begin
            colon_seen_next = 1'b1;
          end
        end else if (c == tcmp_pkg::CH_COMMA) begin
          // Close the field: keep the first two, count commas up to two.
          if (comma_count == 2'd0) begin
            saved_note_next = tcmp_pkg::field_value(field_negative, field_accumulator);
          end else if (comma_count == 2'd1) begin
            saved_velocity_next = tcmp_pkg::field_value(field_negative, field_accumulator);
          end
          if (comma_count != 2'd2) begin
            comma_count_next = comma_count + 2'd1;
          end
          field_phase_next       = tcmp_pkg::PH_BLANK;
          field_negative_next    = 1'b0;
          field_accumulator_next = 8'd0;
        end else begin
          unique case (field_phase)
            tcmp_pkg::PH_BLANK: begin
              if ((c == tcmp_pkg::CH_SPACE) || (c == tcmp_pkg::CH_TAB) ||
                  (c == tcmp_pkg::CH_VTAB) || (c == tcmp_pkg::CH_FEED)) begin
                field_phase_next = tcmp_pkg::PH_BLANK;
              end else if (c == tcmp_pkg::CH_PLUS) begin
                field_phase_next = tcmp_pkg::PH_SIGN;
              end else if (c == tcmp_pkg::CH_MINUS) begin
                field_negative_next = 1'b1;
                field_phase_next    = tcmp_pkg::PH_SIGN;
              end else if (is_digit) begin
                field_accumulator_next = digit_val;
                field_phase_next       = tcmp_pkg::PH_DIGITS;
              end else begin
                field_phase_next = tcmp_pkg::PH_DONE;
              end
            end
            tcmp_pkg::PH_SIGN: begin
              if (is_digit) begin
                field_accumulator_next = digit_val;
                field_phase_next       = tcmp_pkg::PH_DIGITS;
              end else begin
                field_phase_next = tcmp_pkg::PH_DONE;
              end
            end
            tcmp_pkg::PH_DIGITS: begin
              // acc * 10 + d, modulo 256
              if (is_digit) begin
                field_accumulator_next = {field_accumulator[4:0], 3'b000}
                                       + {field_accumulator[6:0], 1'b0} + digit_val;
              end else begin
                field_phase_next = tcmp_pkg::PH_DONE;
              end
            end
            tcmp_pkg::PH_DONE: begin
              field_phase_next = tcmp_pkg::PH_DONE;
            end
            default: begin
              field_phase_next = tcmp_pkg::PH_DONE;
            end
          endcase
        end
      end
    end

    if (char_position != 2'd2) begin
      char_position_next = char_position + 2'd1;
    end
  end

  // Packet contents from the state after this character.
  always_comb begin
    cur_value = tcmp_pkg::field_value(field_negative_next, field_accumulator_next);
    unique case (comma_count_next)
      2'd0: begin
        note     = cur_value;
        velocity = tcmp_pkg::VELOCITY_FULL;
        channel  = 8'd0;
      end
      2'd1: begin
        note     = saved_note_next;
        velocity = cur_value;
        channel  = 8'd0;
      end
      default: begin
        note     = saved_note_next;
        velocity = saved_velocity_next;
        channel  = cur_value;
      end
    endcase

    on_pkt.code_index    = tcmp_pkg::CIN_NOTE_ON;
    on_pkt.status_byte   = tcmp_pkg::STATUS_NOTE_ON | channel;
    on_pkt.note_number   = note;
    on_pkt.note_velocity = velocity;
    on_pkt.last_packet   = (action_kind_next == tcmp_pkg::ACT_PRESS);

    off_pkt.code_index    = tcmp_pkg::CIN_NOTE_OFF;
    off_pkt.status_byte   = tcmp_pkg::STATUS_NOTE_OFF | channel;
    off_pkt.note_number   = note;
    off_pkt.note_velocity = velocity;
    off_pkt.last_packet   = 1'b1;
  end

  assign emit = cmd_xfer && cmd.payload.end_of_command && starts_with_m_next && colon_seen_next;

  // Load both slots when a command ends with packets, else shift the head out on a transfer.
  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    count_next = count;
    if (emit) begin
      slot0_next = (action_kind_next == tcmp_pkg::ACT_RELEASE) ? off_pkt : on_pkt;
      slot1_next = off_pkt;
      count_next = ((action_kind_next == tcmp_pkg::ACT_PRESS) ||
                    (action_kind_next == tcmp_pkg::ACT_RELEASE)) ? 2'd1 : 2'd2;
    end else if (pkt_xfer) begin
      slot0_next = slot1;
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd_xfer && cmd.payload.end_of_command)) begin
      // Every command end drops the parser back to its reset state.
      char_position     <= 2'd0;
      starts_with_m     <= 1'b0;
      line_ended        <= 1'b0;
      action_kind       <= tcmp_pkg::ACT_STROKE;
      colon_seen        <= 1'b0;
      comma_count       <= 2'd0;
      field_phase       <= tcmp_pkg::PH_BLANK;
      field_negative    <= 1'b0;
      field_accumulator <= 8'd0;
      saved_note        <= 8'd0;
      saved_velocity    <= 8'd0;
    end else if (cmd_xfer) begin
      char_position     <= char_position_next;
      starts_with_m     <= starts_with_m_next;
      line_ended        <= line_ended_next;
      action_kind       <= action_kind_next;
      colon_seen        <= colon_seen_next;
      comma_count       <= comma_count_next;
      field_phase       <= field_phase_next;
      field_negative    <= field_negative_next;
      field_accumulator <= field_accumulator_next;
      saved_note        <= saved_note_next;
      saved_velocity    <= saved_velocity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  // Packet register never holds more than two packets.
  `TCMP_ASSERT_SAME(a_count_range, clk, rst, 1'b1, count != 2'd3,
                    "packet register count out of range")
  // A non-final packet is the note-on of a stroke, with its note-off queued behind.
  `TCMP_ASSERT_SAME(a_stroke_pair, clk, rst, pkt.valid && !pkt.payload.last_packet,
                    count == 2'd2, "non-final packet without a queued follower")
  // A character that does not end a command never adds packets.
  `TCMP_ASSERT_NEXT(a_mid_no_growth, clk, rst,
                    cmd.valid && cmd.ready && !cmd.payload.end_of_command,
                    count == 2'd0, "packet appeared for a mid-command character")
  // A following note-off after a stroke is always a note-off.
  `TCMP_ASSERT_SAME(a_tail_off, clk, rst, count == 2'd2,
                    slot1.code_index == tcmp_pkg::CIN_NOTE_OFF,
                    "queued second packet is not a note-off")

endmodule

### test/text_command_to_midi_packets_tb.sv
// Self-checking testbench for the text command to MIDI packet block.
module text_command_to_midi_packets_tb;

  // Start no new command once this many characters have been transferred.
  localparam int CHAR_TARGET  = 1850;
  // Receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_START   = 300;
  localparam int HOLD_CYCLES  = 250;
  // Window in which neither side idles.
  localparam int QUIET_FROM   = 900;
  localparam int QUIET_TO     = 1500;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Extra cycles after the last expected packet to catch stray output.
  localparam int DRAIN_CYCLES = 10;

  // Tracks the parser state per accepted character and checks the packet stream.
  class packet_scoreboard;
    logic [1:0]        position;
    bit                m_lead;
    bit                cut;
    logic [1:0]        action;
    bit                colon_found;
    logic [1:0]        commas;
    logic [1:0]        phase;
    bit                negative;
    logic [7:0]        magnitude;
    logic [7:0]        first_field;
    logic [7:0]        second_field;
    tcmp_pkg::packet_t due_packets[$];
    int                mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void restart_field();
      phase     = tcmp_pkg::PH_BLANK;
      negative  = 1'b0;
      magnitude = 8'd0;
    endfunction

    function void clear();
      position     = 2'd0;
      m_lead       = 1'b0;
      cut          = 1'b0;
      action       = tcmp_pkg::ACT_STROKE;
      colon_found  = 1'b0;
      commas       = 2'd0;
      first_field  = 8'd0;
      second_field = 8'd0;
      restart_field();
    endfunction

    function logic [7:0] field_now();
      return negative ? (~magnitude + 8'd1) : magnitude;
    endfunction

    // atol-style field scan: blanks, optional sign, digits, anything else ends it.
    function void scan_field(logic [7:0] c);
      bit         is_digit;
      logic [7:0] d;
      is_digit = (c >= tcmp_pkg::CH_ZERO) && (c <= tcmp_pkg::CH_NINE);
      d = c - tcmp_pkg::CH_ZERO;
      case (phase)
        tcmp_pkg::PH_BLANK: begin
          if (!(c == tcmp_pkg::CH_SPACE || c == tcmp_pkg::CH_TAB ||
                c == tcmp_pkg::CH_VTAB || c == tcmp_pkg::CH_FEED)) begin
            if (c == tcmp_pkg::CH_PLUS) begin
              phase = tcmp_pkg::PH_SIGN;
            end else if (c == tcmp_pkg::CH_MINUS) begin
              negative = 1'b1;
              phase    = tcmp_pkg::PH_SIGN;
            end else if (is_digit) begin
              magnitude = d;
              phase     = tcmp_pkg::PH_DIGITS;
            end else begin
              phase = tcmp_pkg::PH_DONE;
            end
          end
        end
        tcmp_pkg::PH_SIGN: begin
          if (is_digit) begin
            magnitude = d;
            phase     = tcmp_pkg::PH_DIGITS;
          end else begin
            phase = tcmp_pkg::PH_DONE;
          end
        end
        tcmp_pkg::PH_DIGITS: begin
          if (is_digit) magnitude = magnitude * 8'd10 + d;
          else phase = tcmp_pkg::PH_DONE;
        end
        default: ;
      endcase
    endfunction

    // Note one accepted character; queue the packets it causes.
    function void take_char(tcmp_pkg::char_item_t item);
      logic [7:0]        c;
      logic [7:0]        chan;
      logic [7:0]        note;
      logic [7:0]        vel;
      tcmp_pkg::packet_t p;
      c = item.char_byte;
      if (position == 2'd0) begin
        m_lead = (c == tcmp_pkg::CH_M);
      end else if (m_lead && !cut) begin
        if (c == tcmp_pkg::CH_LF || c == tcmp_pkg::CH_CR) begin
          cut = 1'b1;
        end else begin
          if (position == 2'd1)
            action = (c == tcmp_pkg::CH_P) ? tcmp_pkg::ACT_PRESS :
                     (c == tcmp_pkg::CH_R) ? tcmp_pkg::ACT_RELEASE : tcmp_pkg::ACT_STROKE;
          if (!colon_found) begin
            if (c == tcmp_pkg::CH_COLON) colon_found = 1'b1;
          end else if (c == tcmp_pkg::CH_COMMA) begin
            if (commas == 2'd0) first_field = field_now();
            else if (commas == 2'd1) second_field = field_now();
            if (commas < 2'd2) commas++;
            restart_field();
          end else begin
            scan_field(c);
          end
        end
      end
      if (position < 2'd2) position++;

      if (item.end_of_command) begin
        if (m_lead && colon_found) begin
          chan = 8'd0;
          if (commas == 2'd0) begin
            note = field_now();
            vel  = tcmp_pkg::VELOCITY_FULL;
          end else if (commas == 2'd1) begin
            note = first_field;
            vel  = field_now();
          end else begin
            note = first_field;
            vel  = second_field;
            chan = field_now();
          end
          p.status_byte   = 8'd0;
          p.note_number   = note;
          p.note_velocity = vel;
          if (action != tcmp_pkg::ACT_RELEASE) begin
            p.code_index  = tcmp_pkg::CIN_NOTE_ON;
            p.status_byte = tcmp_pkg::STATUS_NOTE_ON | chan;
            p.last_packet = (action == tcmp_pkg::ACT_PRESS);
            due_packets.push_back(p);
          end
          if (action != tcmp_pkg::ACT_PRESS) begin
            p.code_index  = tcmp_pkg::CIN_NOTE_OFF;
            p.status_byte = tcmp_pkg::STATUS_NOTE_OFF | chan;
            p.last_packet = 1'b1;
            due_packets.push_back(p);
          end
        end
        clear();
      end
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_packet(tcmp_pkg::packet_t got);
      tcmp_pkg::packet_t want;
      if (due_packets.size() == 0) begin
        $display("%0t: unexpected packet, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = due_packets.pop_front();
      compare("code_index", want.code_index, got.code_index);
      compare("status_byte", want.status_byte, got.status_byte);
      compare("note_number", want.note_number, got.note_number);
      compare("note_velocity", want.note_velocity, got.note_velocity);
      compare("last_packet", want.last_packet, got.last_packet);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcmp_stream_if #(.payload_t(tcmp_pkg::char_item_t)) cmd_if ();
  tcmp_stream_if #(.payload_t(tcmp_pkg::packet_t))    pkt_if ();

  text_command_to_midi_packets i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .pkt (pkt_if)
  );

  packet_scoreboard packet_sb = new();

  int         cycle_count  = 0;
  int         hold_left    = 0;
  int         stall_cycles = 0;
  int         chars_sent   = 0;
  // Characters of the command being built, sent as one command.
  logic [7:0] text[$];

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic bit quiet_stretch();
    return (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);
  endfunction

  // Packet side: random stalls, one long hold-off, and a window with none.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      pkt_if.ready <= 1'b0;
    end else if (cycle_count == HOLD_START) begin
      hold_left    <= HOLD_CYCLES;
      pkt_if.ready <= 1'b0;
    end else begin
      pkt_if.ready <= quiet_stretch() || ($urandom_range(0, 99) >= 7);
    end
  end

  // Check output transfers first, then note the input transfer of the same edge.
  // Packets only appear after their last character has been taken, so the order only
  // keeps the log readable.
  always @(posedge clk) begin
    if (!rst) begin
      if (pkt_if.valid && pkt_if.ready) packet_sb.check_packet(pkt_if.payload);
      if (cmd_if.valid && cmd_if.ready) packet_sb.take_char(cmd_if.payload);
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (pkt_if.valid && pkt_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void put(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] any_letter();
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0: return tcmp_pkg::CH_SPACE;
      1: return tcmp_pkg::CH_TAB;
      2: return tcmp_pkg::CH_VTAB;
      default: return tcmp_pkg::CH_FEED;
    endcase
  endfunction

  function automatic logic [7:0] any_line_end();
    return $urandom_range(0, 1) ? tcmp_pkg::CH_CR : tcmp_pkg::CH_LF;
  endfunction

  // Append one numeric field: blanks, sign, mostly short digit runs, rarely long ones
  // that wrap, and now and then trailing junk that ends the field early.
  function automatic void put_field();
    int sign_pick;
    int digits;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(any_blank());
    end
    sign_pick = $urandom_range(0, 9);
    if (sign_pick < 2) text.push_back(tcmp_pkg::CH_MINUS);
    else if (sign_pick == 2) text.push_back(tcmp_pkg::CH_PLUS);
    digits = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
    repeat (digits) text.push_back(tcmp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 14) == 0) begin
      text.push_back($urandom_range(0, 1) ? any_letter() : tcmp_pkg::CH_COLON);
      if ($urandom_range(0, 1)) text.push_back(tcmp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  // Mostly well-formed commands with random content; the rest broken or pure noise.
  function automatic void make_random_command();
    int kind;
    int fields;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      text.push_back(tcmp_pkg::CH_M);
      case ($urandom_range(0, 2))
        0: text.push_back(tcmp_pkg::CH_P);
        1: text.push_back(tcmp_pkg::CH_R);
        default: text.push_back(any_byte());
      endcase
      repeat ($urandom_range(0, 2)) text.push_back(any_letter());
      text.push_back(tcmp_pkg::CH_COLON);
      fields = $urandom_range(1, 5);
      for (int f = 0; f < fields; f++) begin
        if (f > 0) text.push_back(tcmp_pkg::CH_COMMA);
        put_field();
      end
      if ($urandom_range(0, 19) == 0) begin
        text.push_back(any_line_end());
        repeat ($urandom_range(0, 4)) text.push_back(any_byte());
      end
    end else if (kind < 90) begin
      case ($urandom_range(0, 2))
        0: begin
          // wrong lead character
          text.push_back(any_byte());
          text.push_back(tcmp_pkg::CH_P);
          text.push_back(tcmp_pkg::CH_COLON);
          put_field();
        end
        1: begin
          // no colon
          text.push_back(tcmp_pkg::CH_M);
          text.push_back($urandom_range(0, 1) ? tcmp_pkg::CH_P : tcmp_pkg::CH_R);
          put_field();
        end
        default: begin
          // line cut before the colon
          text.push_back(tcmp_pkg::CH_M);
          text.push_back(tcmp_pkg::CH_P);
          text.push_back(any_line_end());
          text.push_back(tcmp_pkg::CH_COLON);
          put_field();
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) text.push_back(any_byte());
    end
  endfunction

  // Offer one character and hold it until it transfers; sometimes idle first.
  task automatic offer_char(input logic [7:0] c, input logic last);
    tcmp_pkg::char_item_t item;
    if (!quiet_stretch() && $urandom_range(0, 99) < 7) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item.char_byte      = c;
    item.end_of_command = last;
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= item;
    do @(posedge clk); while (!cmd_if.ready);
    chars_sent++;
  endtask

  // Send the built command, end flag on its final character, then drop it.
  task automatic send_text();
    for (int i = 0; i < text.size(); i++) offer_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  initial begin
    cmd_if.valid   <= 1'b0;
    cmd_if.payload <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Press, release and stroke with the plain field forms.
    put("MP:60");            send_text();
    put("MR:60,0");          send_text();
    put("MS:255,255,255");   send_text();
    // Blank before a sign, plus sign, wrap past 255, channel above 15.
    put("MX: -1,+300,16");   send_text();
    // Every skipped blank kind ahead of a negative value.
    put("MP:");
    text.push_back(tcmp_pkg::CH_TAB);
    text.push_back(tcmp_pkg::CH_VTAB);
    text.push_back(tcmp_pkg::CH_FEED);
    put(" -7");              send_text();
    // Empty fields read as zero.
    put("Mq:,,");            send_text();
    // A later colon ends the field.
    put("MP:5:6");           send_text();
    // Text after a CR is ignored.
    put("MR:5");
    text.push_back(tcmp_pkg::CH_CR);
    put("9,9");              send_text();
    // Not an M command, and an M command without a colon.
    put("XP:1");             send_text();
    put("MP1");              send_text();
    // Channel comes from the field after the last comma.
    put("MS:1,2,3,4,200");   send_text();
    put("M");                send_text();
    // Sign without digits, junk, and digits cut by a letter.
    put("MP:-,+x,12a3");     send_text();
    // LF before the colon.
    put("MR");
    text.push_back(tcmp_pkg::CH_LF);
    put(":5");               send_text();
    text.push_back(8'hFF);   send_text();
    // Colon as the second character: stroke.
    put("M:3");              send_text();
    put("MP:999999");        send_text();

    while (chars_sent < CHAR_TARGET) begin
      make_random_command();
      send_text();
    end
    cmd_if.valid <= 1'b0;

    // Drain: the watchdog bounds this wait.
    while (packet_sb.due_packets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (packet_sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
